@@ src/battery_status_line_monitor_assert.svh @@
// ----------------------------------------------------------------------------
// Battery status line monitor: assertion macros
// Shared concurrent assertion forms used by the monitor's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef BATTERY_STATUS_LINE_MONITOR_ASSERT_SVH
`define BATTERY_STATUS_LINE_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bslm_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery status line monitor package
// Types, character codes, line layout and the cell and gauge checks.
// ----------------------------------------------------------------------------
package bslm_pkg;

    // Operation carried by an input word.
    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_TIMEOUT   = 2'd1,
        OP_POWER_ACK = 2'd2,
        OP_RESERVED  = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic {
        REG_CELL_LOW  = 1'b0,
        REG_GAUGE_LOW = 1'b1
    } t_reg_idx;

    // Phases of the atoi-style gauge scan.
    typedef enum logic [1:0] {
        SCAN_SPACE,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       power_on;
    } t_item;

    typedef struct packed {
        logic line_ok;
        logic low_battery;
        logic power_off_request;
        logic power_state_valid;
        logic computer_on;
    } t_result;

    localparam int LINE_CAPACITY_DEF = 63;
    localparam int CFG_W             = 7;
    localparam int NUM_CELLS         = 8;
    localparam int CELL_SPAN         = 3 * NUM_CELLS;
    localparam int LAST_EMPTY_POS    = 3 * (NUM_CELLS - 1);
    localparam int GAUGE_POS         = 39;
    localparam int GAUGE_LEN         = 3;
    localparam int POWER_POS         = 44;

    localparam logic [CFG_W-1:0] CELL_LOW_RST  = 7'd30;
    localparam logic [CFG_W-1:0] GAUGE_LOW_RST = 7'd10;
    localparam logic [CFG_W-1:0] CELL_MAX      = 7'd99;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_ONE   = 8'd49;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_QMARK = 8'd63;
    localparam logic [7:0] CHAR_P     = 8'd80;

    // A cell reads (tens - '0') * 10 + (ones - '0') on signed characters,
    // clamped to 0..99, and is low when below the threshold.
    function automatic logic cell_is_low(input logic [7:0] tens,
                                         input logic [7:0] ones,
                                         input logic [CFG_W-1:0] thr);
        logic signed [7:0]  ts;
        logic signed [7:0]  os;
        logic signed [11:0] v;
        logic               low;
        ts = tens;
        os = ones;
        v  = (ts - 12'sd48) * 12'sd10 + (os - 12'sd48);
        if (v < 12'sd0) begin
            low = (thr != '0);
        end else if (v > 12'sd99) begin
            low = (CELL_MAX < thr);
        end else begin
            low = (v[CFG_W-1:0] < thr);
        end
        return low;
    endfunction

    // Gauge read like atoi over three characters, then compared.
    function automatic logic gauge_is_low(input logic [7:0] g0,
                                          input logic [7:0] g1,
                                          input logic [7:0] g2,
                                          input logic [CFG_W-1:0] thr);
        logic [7:0]  chars [GAUGE_LEN];
        logic [7:0]  c;
        logic [9:0]  acc;
        logic        neg;
        logic        is_digit;
        t_scan       st;
        chars[0] = g0;
        chars[1] = g1;
        chars[2] = g2;
        acc      = '0;
        neg      = 1'b0;
        st       = SCAN_SPACE;
        for (int k = 0; k < GAUGE_LEN; k++) begin
            c        = chars[k];
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            case (st)
                SCAN_SPACE: begin
                    if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
                        st = SCAN_SPACE;
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        neg = (c == CHAR_MINUS);
                        st  = SCAN_DIGITS;
                    end else if (is_digit) begin
                        acc = 10'(c - CHAR_ZERO);
                        st  = SCAN_DIGITS;
                    end else begin
                        st = SCAN_DONE;
                    end
                end
                SCAN_DIGITS: begin
                    if (is_digit) begin
                        acc = 10'(acc * 10'd10) + 10'(c - CHAR_ZERO);
                    end else begin
                        st = SCAN_DONE;
                    end
                end
                default: begin
                    st = SCAN_DONE;
                end
            endcase
        end
        // A negative reading is always below a threshold that is not zero.
        if (neg) begin
            return (acc != '0) || (thr != '0);
        end
        return (acc < {3'b000, thr});
    endfunction

endpackage

@@ src/battery_status_line_monitor.sv @@
// ----------------------------------------------------------------------------
// Battery status line monitor
// Watches a power controller's status lines for low cells, a low charge
// gauge and an unexpected power-off report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per cycle unless
//   stalled: a received byte, a receive timeout, or a power command acknowledge.
//   Output channel (o_out_valid / i_out_stall) returns one result word for
//   each carriage return and each timeout; other words give no result.
//   A word is held in the input register, then evaluated into the result
//   register. Throughput: one word per cycle unless the receiver stalls,
//   set by the single evaluation stage.
//   When the receiver stalls, the result register holds its word and the
//   input register takes one more word; o_in_stall then rises until the
//   result is taken.
//   Reset (synchronous, active low) clears the line, the power expectation
//   and both stages, and loads the threshold registers with their defaults.
//   Thresholds are written through i_cfg_we / i_cfg_index / i_cfg_wdata
//   while the block is idle.
// ----------------------------------------------------------------------------
module battery_status_line_monitor
    import bslm_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_data_byte,
    input  logic             i_power_on,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_line_ok,
    output logic             o_low_battery,
    output logic             o_power_off_request,
    output logic             o_power_state_valid,
    output logic             o_computer_on
);

    `include "battery_status_line_monitor_assert.svh"

    logic [CFG_W-1:0] r_cell_low;
    logic [CFG_W-1:0] r_gauge_low;
    logic             r_in_valid, n_in_valid;
    t_item            r_in_item;
    logic             in_accept;
    logic             out_free;
    logic             fire;
    logic             res_valid;
    t_result          result;
    t_result          out_result;

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_low  <= CELL_LOW_RST;
            r_gauge_low <= GAUGE_LOW_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CELL_LOW:  r_cell_low  <= i_cfg_wdata;
                REG_GAUGE_LOW: r_gauge_low <= i_cfg_wdata;
                default:       r_cell_low  <= r_cell_low;
            endcase
        end
    end

    // Input register: a word moves on whenever the result slot is free.
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.op        <= t_op'(i_op);
            r_in_item.data_byte <= i_data_byte;
            r_in_item.power_on  <= i_power_on;
        end
    end

    // Line evaluation.
    bslm_line_eval #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_cell_low  (r_cell_low),
        .i_gauge_low (r_gauge_low),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // Result register.
    bslm_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && res_valid),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_line_ok           = out_result.line_ok;
    assign o_low_battery       = out_result.low_battery;
    assign o_power_off_request = out_result.power_off_request;
    assign o_power_state_valid = out_result.power_state_valid;
    assign o_computer_on       = out_result.computer_on;

    // A timeout leaving the input stage shows up as an all-zero result.
    `BSLM_ASSERT_NEXT(a_timeout_zero, i_clk, i_rst_n,
        fire && r_in_item.op == OP_TIMEOUT,
        o_out_valid && !o_line_ok && !o_low_battery && !o_power_state_valid,
        "timeout did not give an all-zero result")

    // A carriage return leaving the input stage gives a completed-line result.
    `BSLM_ASSERT_NEXT(a_cr_result, i_clk, i_rst_n,
        fire && r_in_item.op == OP_BYTE && r_in_item.data_byte == CHAR_CR,
        o_out_valid && o_line_ok,
        "carriage return did not give a line result")

    // Power flags only appear with a valid power state.
    `BSLM_ASSERT_NOW(a_power_flags, i_clk, i_rst_n,
        o_out_valid && !o_power_state_valid,
        !o_computer_on && !o_power_off_request,
        "power flags set without a valid power state")

endmodule

@@ src/bslm_result_reg.sv @@
// ----------------------------------------------------------------------------
// Battery status line monitor: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module bslm_result_reg
    import bslm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The slot is free when empty or when its word leaves this cycle.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/bslm_line_eval.sv @@
// ----------------------------------------------------------------------------
// Battery status line monitor: line evaluator
// Keeps the per-line state and evaluates a line when it ends.
// ----------------------------------------------------------------------------
module bslm_line_eval
    import bslm_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_cell_low,
    input  logic [CFG_W-1:0] i_gauge_low,
    output logic             o_res_valid,
    output t_result          o_result
);

    localparam int POS_W = $clog2(LINE_CAPACITY + 1);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_tens,  n_tens;
    logic             r_low,   n_low;
    logic [7:0]       r_gauge [GAUGE_LEN];
    logic [7:0]       n_gauge [GAUGE_LEN];
    logic             r_marker, n_marker;
    logic [7:0]       r_digit,  n_digit;
    logic             r_exp_on, n_exp_on;

    logic             res_valid;
    t_result          result;
    logic             pwr_valid;
    logic             pwr_on;
    logic [POS_W-1:0] gauge_off;

    assign gauge_off = r_pos - POS_W'(GAUGE_POS);

    // Next state and result for the word in the input stage.
    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_tens    = r_tens;
        n_low     = r_low;
        n_gauge   = r_gauge;
        n_marker  = r_marker;
        n_digit   = r_digit;
        n_exp_on  = r_exp_on;
        res_valid = 1'b0;
        result    = '0;
        pwr_valid = r_marker && (r_digit == CHAR_ZERO || r_digit == CHAR_ONE);
        pwr_on    = pwr_valid && (r_digit == CHAR_ONE);

        case (i_item.op)
            OP_BYTE: begin
                if (i_item.data_byte == CHAR_NUL) begin
                    res_valid = 1'b0;
                end else if (i_item.data_byte == CHAR_CR) begin
                    // End of line: fold in cells never completed and the gauge.
                    res_valid          = 1'b1;
                    result.line_ok     = 1'b1;
                    result.low_battery = r_low;
                    if (r_pos <= POS_W'(LAST_EMPTY_POS)
                        && cell_is_low(CHAR_NUL, CHAR_NUL, i_cell_low)) begin
                        result.low_battery = 1'b1;
                    end
                    if (r_pos < POS_W'(CELL_SPAN) && r_phase == 2'd1
                        && cell_is_low(r_tens, CHAR_NUL, i_cell_low)) begin
                        result.low_battery = 1'b1;
                    end
                    if (r_gauge[0] != CHAR_QMARK
                        && gauge_is_low(r_gauge[0], r_gauge[1], r_gauge[2],
                                        i_gauge_low)) begin
                        result.low_battery = 1'b1;
                    end
                    result.power_state_valid = pwr_valid;
                    result.computer_on       = pwr_on;
                    result.power_off_request = pwr_valid && !pwr_on && r_exp_on;
                    if (pwr_valid) begin
                        n_exp_on = pwr_on;
                    end
                    n_pos    = '0;
                    n_phase  = '0;
                    n_tens   = '0;
                    n_low    = 1'b0;
                    n_gauge  = '{default: '0};
                    n_marker = 1'b0;
                    n_digit  = '0;
                end else if (r_pos < POS_W'(LINE_CAPACITY)) begin
                    // Keep the character by its position in the line.
                    if (r_pos < POS_W'(CELL_SPAN)) begin
                        if (r_phase == 2'd0) begin
                            n_tens = i_item.data_byte;
                        end else if (r_phase == 2'd1
                                     && cell_is_low(r_tens, i_item.data_byte,
                                                    i_cell_low)) begin
                            n_low = 1'b1;
                        end
                        n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                    end
                    if (r_pos >= POS_W'(GAUGE_POS)
                        && r_pos < POS_W'(GAUGE_POS + GAUGE_LEN)) begin
                        n_gauge[gauge_off[1:0]] = i_item.data_byte;
                    end
                    if (r_pos == POS_W'(POWER_POS)) begin
                        n_marker = (i_item.data_byte == CHAR_P);
                    end
                    if (r_pos == POS_W'(POWER_POS + 1)) begin
                        n_digit = i_item.data_byte;
                    end
                    n_pos = r_pos + POS_W'(1);
                end
            end
            OP_TIMEOUT: begin
                // All-zero result and a fresh line; the power expectation stays.
                res_valid = 1'b1;
                n_pos     = '0;
                n_phase   = '0;
                n_tens    = '0;
                n_low     = 1'b0;
                n_gauge   = '{default: '0};
                n_marker  = 1'b0;
                n_digit   = '0;
            end
            OP_POWER_ACK: begin
                n_exp_on = i_item.power_on;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Line state advances only when a word leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= '0;
            r_tens   <= '0;
            r_low    <= 1'b0;
            r_gauge  <= '{default: '0};
            r_marker <= 1'b0;
            r_digit  <= '0;
            r_exp_on <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_tens   <= n_tens;
            r_low    <= n_low;
            r_gauge  <= n_gauge;
            r_marker <= n_marker;
            r_digit  <= n_digit;
            r_exp_on <= n_exp_on;
        end
    end

    assign o_res_valid = res_valid;
    assign o_result    = result;

endmodule

@@ bench/line_verdict_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status line verdict board
// Predicts the verdict word of the battery status line monitor for every
// accepted input word and checks each returned verdict against the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
package line_verdict_pkg;

    import bslm_pkg::*;

    class line_verdict_board;

        // Alert thresholds, mirrored from the register writes.
        logic [CFG_W-1:0] cell_thr;
        logic [CFG_W-1:0] gauge_thr;

        // Partial line being collected.
        int unsigned      kept_count;
        logic [7:0]       tens_ch;
        bit               cell_low_seen;
        logic [7:0]       gauge_ch [GAUGE_LEN];
        bit               p_marker;
        logic [7:0]       state_ch;
        bit               expect_on;

        // Verdicts predicted but not yet returned.
        t_result          pending_verdicts [$];

        int unsigned      verdicts_expected;
        int unsigned      verdicts_checked;
        int unsigned      lines_closed;
        int unsigned      timeouts_seen;
        int unsigned      mismatches;

        function new();
            cell_thr          = CELL_LOW_RST;
            gauge_thr         = GAUGE_LOW_RST;
            expect_on         = 1'b0;
            verdicts_expected = 0;
            verdicts_checked  = 0;
            lines_closed      = 0;
            timeouts_seen     = 0;
            mismatches        = 0;
            clear_line();
        endfunction

        function void set_threshold(t_reg_idx idx, logic [CFG_W-1:0] value);
            if (idx == REG_CELL_LOW) begin
                cell_thr = value;
            end else begin
                gauge_thr = value;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void clear_line();
            kept_count    = 0;
            tens_ch       = CHAR_NUL;
            cell_low_seen = 1'b0;
            foreach (gauge_ch[k]) gauge_ch[k] = CHAR_NUL;
            p_marker      = 1'b0;
            state_ch      = CHAR_NUL;
        endfunction

        // Characters count as signed; the reading is clamped to 0..99.
        function bit reads_low(logic [7:0] tens, logic [7:0] ones);
            int v;
            v = (int'($signed(tens)) - 48) * 10 + (int'($signed(ones)) - 48);
            if (v < 0) v = 0;
            if (v > 99) v = 99;
            return v < int'(cell_thr);
        endfunction

        // Gauge parsed like atoi: white space, optional sign, digits.
        function int gauge_reading();
            int k;
            int acc;
            bit neg;
            k   = 0;
            acc = 0;
            neg = 1'b0;
            while (k < GAUGE_LEN && (gauge_ch[k] == CHAR_SPACE ||
                   (gauge_ch[k] >= CHAR_TAB && gauge_ch[k] <= CHAR_CR)))
                k++;
            if (k < GAUGE_LEN && (gauge_ch[k] == CHAR_PLUS || gauge_ch[k] == CHAR_MINUS)) begin
                neg = (gauge_ch[k] == CHAR_MINUS);
                k++;
            end
            while (k < GAUGE_LEN && gauge_ch[k] >= CHAR_ZERO && gauge_ch[k] <= CHAR_NINE) begin
                acc = acc * 10 + int'(gauge_ch[k] - CHAR_ZERO);
                k++;
            end
            return neg ? -acc : acc;
        endfunction

        // Keep one character at the next line position, dropping overflow.
        function void store_char(logic [7:0] c);
            int unsigned p;
            p = kept_count;
            if (p >= LINE_CAPACITY_DEF) return;
            if (p < CELL_SPAN) begin
                if (p % 3 == 0) begin
                    tens_ch = c;
                end else if (p % 3 == 1 && reads_low(tens_ch, c)) begin
                    cell_low_seen = 1'b1;
                end
            end
            if (p >= GAUGE_POS && p < GAUGE_POS + GAUGE_LEN) gauge_ch[p - GAUGE_POS] = c;
            if (p == POWER_POS) p_marker = (c == CHAR_P);
            if (p == POWER_POS + 1) state_ch = c;
            kept_count = p + 1;
        endfunction

        // Evaluate the line at its carriage return.
        function t_result close_line();
            t_result    r;
            bit         low;
            logic [7:0] t;
            low = cell_low_seen;
            // Cells whose ones digit never arrived read it as a NUL.
            for (int i = 0; i < NUM_CELLS; i++) begin
                if (3 * i + 1 < kept_count) continue;
                t = (3 * i < kept_count) ? tens_ch : CHAR_NUL;
                if (reads_low(t, CHAR_NUL)) low = 1'b1;
            end
            if (gauge_ch[0] != CHAR_QMARK && gauge_reading() < int'(gauge_thr)) low = 1'b1;
            r             = '0;
            r.line_ok     = 1'b1;
            r.low_battery = low;
            if (p_marker && (state_ch == CHAR_ZERO || state_ch == CHAR_ONE)) begin
                r.power_state_valid = 1'b1;
                r.computer_on       = (state_ch == CHAR_ONE);
                r.power_off_request = !r.computer_on && expect_on;
                expect_on           = r.computer_on;
            end
            clear_line();
            lines_closed++;
            return r;
        endfunction

        // Note one accepted input word and queue the verdict it causes.
        function void note_word(t_op op, logic [7:0] ch, logic pwr);
            case (op)
                OP_BYTE: begin
                    if (ch == CHAR_CR) begin
                        pending_verdicts.push_back(close_line());
                        verdicts_expected++;
                    end else if (ch != CHAR_NUL) begin
                        store_char(ch);
                    end
                end
                OP_TIMEOUT: begin
                    pending_verdicts.push_back(t_result'('0));
                    verdicts_expected++;
                    timeouts_seen++;
                    clear_line();
                end
                OP_POWER_ACK: begin
                    expect_on = pwr;
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare a returned verdict, field by field, with the oldest one.
        task check_verdict(t_result got);
            string      field_name [5] = '{"computer_on", "power_state_valid",
                                           "power_off_request", "low_battery", "line_ok"};
            t_result    want;
            logic [4:0] diff;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("verdict %b arrived with none expected", got));
            end else begin
                want = pending_verdicts.pop_front();
                diff = got ^ want;
                for (int b = 0; b < 5; b++) begin
                    if (diff[b]) begin
                        report($sformatf("verdict %0d field %s got %b expected %b",
                                         verdicts_checked, field_name[b], got[b], want[b]));
                    end
                end
            end
            verdicts_checked++;
        endtask

        task flag_leftovers();
            if (pending_verdicts.size() != 0) begin
                report($sformatf("%0d expected verdicts never arrived",
                                 pending_verdicts.size()));
            end
        endtask

    endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery status line monitor testbench
// Feeds directed and random status lines, timeouts and power acknowledges
// through the valid/stall input channel under several alert thresholds, with
// random idling on both sides, and checks every verdict word.
// ----------------------------------------------------------------------------
module tb_top;

    import bslm_pkg::*;
    import line_verdict_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int PHASE_WORDS    = 440;
    localparam int NUM_PHASES     = 4;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    t_reg_idx         cfg_index = REG_CELL_LOW;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_op              in_op = OP_BYTE;
    logic [7:0]       in_byte = '0;
    logic             in_power = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             out_line_ok;
    logic             out_low_battery;
    logic             out_power_off_request;
    logic             out_power_state_valid;
    logic             out_computer_on;

    line_verdict_board board = new();

    bit          no_idle = 1'b0;
    bit          hold_toggle = 1'b0;
    int unsigned words_counted = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  line_text [$];

    battery_status_line_monitor dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_op                (in_op),
        .i_data_byte         (in_byte),
        .i_power_on          (in_power),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_line_ok           (out_line_ok),
        .o_low_battery       (out_low_battery),
        .o_power_off_request (out_power_off_request),
        .o_power_state_valid (out_power_state_valid),
        .o_computer_on       (out_computer_on)
    );

    // 50 MHz clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Verdict receiver: checks each accepted word, then picks the next stall.
    // A toggle of hold_toggle starts a long hold-off counted here.
    initial begin : verdict_sink
        bit      seen_toggle;
        int      hold_left;
        t_result got;
        seen_toggle = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got = t_result'({out_line_ok, out_low_battery, out_power_off_request,
                                 out_power_state_valid, out_computer_on});
                board.check_verdict(got);
            end
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !no_idle && ($urandom_range(99) < 7);
            end
        end
    end

    // Offer one word, idling first now and then, and wait until it is taken.
    task automatic send_word(t_op op, logic [7:0] ch, logic pwr);
        int gap;
        if (!no_idle && $urandom_range(99) < 7) begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_op    <= op;
        in_byte  <= ch;
        in_power <= pwr;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_word(op, ch, pwr);
        if (op != OP_RESERVED && !(op == OP_BYTE && ch == CHAR_NUL)) words_counted++;
    endtask

    // Stop offering and wait until every verdict is back and the pipe is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both thresholds on consecutive cycles while the block is idle.
    task automatic write_thresholds(logic [CFG_W-1:0] cell_limit,
                                    logic [CFG_W-1:0] gauge_limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CELL_LOW;
        cfg_wdata <= cell_limit;
        @(posedge clk);
        cfg_index <= REG_GAUGE_LOW;
        cfg_wdata <= gauge_limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_threshold(REG_CELL_LOW, cell_limit);
        board.set_threshold(REG_GAUGE_LOW, gauge_limit);
    endtask

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 1));
        return (c == CHAR_CR) ? CHAR_SPACE : c;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(126, 32));
    endfunction

    function automatic logic [7:0] digit();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    // Build one line: mostly laid out like a real status report, some cut
    // short or overlong, and some plain noise.
    function automatic void compose_line();
        int         kind;
        int         len;
        bit         healthy;
        logic [7:0] c;
        logic [7:0] gauge_txt [GAUGE_LEN];
        line_text.delete();
        kind = $urandom_range(99);
        if (kind >= 80) begin
            len = $urandom_range(70, 1);
            for (int p = 0; p < len; p++) line_text.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind < 12) begin
            len = $urandom_range(75, 60);
        end else if (kind < 60) begin
            len = $urandom_range(52, 46);
        end else begin
            len = $urandom_range(45, 0);
        end
        healthy = 1'($urandom_range(1));
        case ($urandom_range(7))
            0: gauge_txt = '{CHAR_QMARK, printable(), printable()};
            1: gauge_txt = '{digit(), digit(), digit()};
            2: gauge_txt = '{CHAR_SPACE, digit(), digit()};
            3: gauge_txt = '{8'($urandom_range(12, 9)), CHAR_SPACE, digit()};
            4: gauge_txt = '{$urandom_range(1) ? CHAR_MINUS : CHAR_PLUS, digit(), digit()};
            5: gauge_txt = '{CHAR_ONE, CHAR_ZERO, CHAR_ZERO};
            6: gauge_txt = '{printable(), printable(), printable()};
            default: gauge_txt = '{digit(), printable(), digit()};
        endcase
        for (int p = 0; p < len; p++) begin
            if (p < CELL_SPAN) begin
                if (p % 3 == 2) begin
                    c = CHAR_SPACE;
                end else if ($urandom_range(19) == 0) begin
                    c = any_char();
                end else if (p % 3 == 0 && healthy) begin
                    c = CHAR_ZERO + 8'($urandom_range(9, 4));
                end else begin
                    c = digit();
                end
            end else if (p >= GAUGE_POS && p < GAUGE_POS + GAUGE_LEN) begin
                c = gauge_txt[p - GAUGE_POS];
            end else if (p == POWER_POS) begin
                c = ($urandom_range(9) == 0) ? printable() : CHAR_P;
            end else if (p == POWER_POS + 1) begin
                if ($urandom_range(7) == 0) begin
                    c = any_char();
                end else begin
                    c = $urandom_range(1) ? CHAR_ONE : CHAR_ZERO;
                end
            end else begin
                c = printable();
            end
            line_text.push_back(c);
        end
    endfunction

    // Send the composed line with stray NULs, sometimes cut by a timeout.
    task automatic send_line();
        bit cut;
        cut = 1'b0;
        foreach (line_text[i]) begin
            if ($urandom_range(99) < 3) send_word(OP_BYTE, CHAR_NUL, 1'($urandom_range(1)));
            if ($urandom_range(199) < 3) begin
                send_word(OP_TIMEOUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
                cut = 1'b1;
                break;
            end
            send_word(OP_BYTE, line_text[i], 1'($urandom_range(1)));
        end
        if (!cut) send_word(OP_BYTE, CHAR_CR, 1'($urandom_range(1)));
    endtask

    // One random step: a line most of the time, else a lone control word.
    task automatic random_step();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            send_word(OP_POWER_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (r < 6) begin
            send_word(OP_RESERVED, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (r < 9) begin
            send_word(OP_TIMEOUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            compose_line();
            send_line();
        end
    endtask

    initial begin : stimulus
        int unsigned phase_end;
        int unsigned base_words;
        bit          paused;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_thresholds(CELL_LOW_RST, GAUGE_LOW_RST);

        // Directed words: empty line, ignored words, short lines with
        // missing cells, negative characters, timeout and acknowledges.
        send_word(OP_BYTE, CHAR_CR, 1'b0);
        send_word(OP_BYTE, CHAR_NUL, 1'b1);
        send_word(OP_RESERVED, 8'hFF, 1'b1);
        send_word(OP_POWER_ACK, 8'h00, 1'b1);
        send_word(OP_BYTE, CHAR_ZERO + 8'd5, 1'b0);
        send_word(OP_BYTE, CHAR_ZERO, 1'b0);
        send_word(OP_BYTE, CHAR_CR, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b0);
        send_word(OP_BYTE, 8'h80, 1'b1);
        send_word(OP_BYTE, CHAR_CR, 1'b0);
        send_word(OP_BYTE, CHAR_NINE, 1'b0);
        send_word(OP_TIMEOUT, 8'hAA, 1'b1);
        send_word(OP_POWER_ACK, 8'h55, 1'b0);
        send_word(OP_BYTE, CHAR_NINE, 1'b0);
        send_word(OP_BYTE, CHAR_NINE, 1'b0);
        send_word(OP_BYTE, CHAR_QMARK, 1'b1);
        send_word(OP_BYTE, CHAR_CR, 1'b1);
        base_words = words_counted;

        // Random phases, each under its own thresholds.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: write_thresholds(7'd0, 7'd0);
                1: write_thresholds(CELL_MAX, 7'd100);
                2: write_thresholds(7'($urandom_range(99)), 7'($urandom_range(100)));
                default: write_thresholds(7'd45, 7'd50);
            endcase
            // Long receiver hold-off while lines keep coming.
            if (phase == 1) hold_toggle = !hold_toggle;
            no_idle   = (phase == 2);
            paused    = 1'b0;
            phase_end = base_words + (phase + 1) * PHASE_WORDS;
            while (words_counted < phase_end) begin
                random_step();
                // Once, hold the sender until every verdict is back.
                if (phase == NUM_PHASES - 1 && !paused &&
                    words_counted >= phase_end - PHASE_WORDS / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        board.flag_leftovers();
        $display("Checked %0d verdicts from %0d input words under 5 threshold settings.",
                 board.verdicts_checked, words_counted);
        $display("Lines closed by carriage return: %0d, by timeout: %0d; mismatches: %0d.",
                 board.lines_closed, board.timeouts_seen, board.mismatches);
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/bslm_pkg.sv
src/bslm_result_reg.sv
src/bslm_line_eval.sv
src/battery_status_line_monitor.sv
bench/line_verdict_pkg.sv
bench/tb_top.sv
